// ===== rtl/core/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// shared types, constants and character classes for the source tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int POS_WIDTH   = 16;
  localparam int OUT_W       = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int MAX_RESULTS = 3;

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
  localparam logic [OUT_W-1:0]     OUT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    KIND_INT    = 4'd0,
    KIND_PRINTL = 4'd1,
    KIND_VOID   = 4'd2,
    KIND_SEMI   = 4'd3,
    KIND_EQ     = 4'd4,
    KIND_LPAREN = 4'd5,
    KIND_RPAREN = 4'd6,
    KIND_LBRACE = 4'd7,
    KIND_RBRACE = 4'd8,
    KIND_IDENT  = 4'd9,
    KIND_COLON  = 4'd10,
    KIND_STAR   = 4'd11,
    KIND_PLUS   = 4'd12,
    KIND_MINUS  = 4'd13,
    KIND_SLASH  = 4'd14,
    KIND_END    = 4'd15
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] len;
    logic             last;
    logic             ovf;
  } result_t;

  typedef struct packed {
    logic [1:0]                   count;
    result_t [MAX_RESULTS-1:0]    slot;
  } step_out_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_word_end(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h3a) || (c == 8'h28) || (c == 8'h3b) || (c == 8'h29);
  endfunction

  // punctuation lookup, bit 4 flags a hit
  function automatic logic [4:0] punct_lookup(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    unique case (c)
      8'h3b:   r = {1'b1, KIND_SEMI};
      8'h3d:   r = {1'b1, KIND_EQ};
      8'h28:   r = {1'b1, KIND_LPAREN};
      8'h29:   r = {1'b1, KIND_RPAREN};
      8'h7b:   r = {1'b1, KIND_LBRACE};
      8'h7d:   r = {1'b1, KIND_RBRACE};
      8'h3a:   r = {1'b1, KIND_COLON};
      8'h2a:   r = {1'b1, KIND_STAR};
      8'h2b:   r = {1'b1, KIND_PLUS};
      8'h2d:   r = {1'b1, KIND_MINUS};
      8'h2f:   r = {1'b1, KIND_SLASH};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] void_char(input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0:    r = 8'h76;
      2'd1:    r = 8'h6f;
      2'd2:    r = 8'h69;
      default: r = 8'h64;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] printl_char(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'h70;
      3'd1:    r = 8'h72;
      3'd2:    r = 8'h69;
      3'd3:    r = 8'h6e;
      3'd4:    r = 8'h74;
      3'd5:    r = 8'h6c;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic kind_t word_kind(input logic [POS_WIDTH:0] len,
                                      input logic vm, input logic pm);
    kind_t r;
    if (len == (POS_WIDTH+1)'(4) && vm) begin
      r = KIND_VOID;
    end else if (len == (POS_WIDTH+1)'(6) && pm) begin
      r = KIND_PRINTL;
    end else begin
      r = KIND_IDENT;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [POS_WIDTH:0] v);
    logic [OUT_W-1:0] r;
    if (v > (POS_WIDTH+1)'(OUT_MAX)) begin
      r = OUT_MAX;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stt_lexer.sv =====
// ----------------------------------------------------------------------------
// stt_lexer
// scan state and the per-character decision, up to three tokens per character
// ----------------------------------------------------------------------------
`default_nettype none

module stt_lexer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [7:0]        ch,
  input  wire logic              eoi,
  output stt_pkg::step_out_t     step
);
  import stt_pkg::*;

  mode_t                scan_mode, scan_mode_next;
  logic [POS_WIDTH-1:0] char_position, char_position_next;
  logic [POS_WIDTH-1:0] token_start, token_start_next;
  logic                 void_match, void_match_next;
  logic                 printl_match, printl_match_next;
  logic                 overflow_seen, overflow_seen_next;

  logic                 dig, alp, wend;
  logic [4:0]           pk;
  logic                 in_num, in_word, cont, sat, ovf;
  logic [POS_WIDTH-1:0] idx;
  logic [POS_WIDTH:0]   end_pos, len2;
  mode_t                mode_a;
  logic [POS_WIDTH-1:0] ts_a;
  logic                 vm_a, pm_a;
  result_t [3:0]        cand;
  logic [3:0]           cand_v;
  logic [1:0]           cnt;

  always_comb begin
    dig     = is_digit(ch);
    alp     = is_alpha(ch);
    wend    = is_word_end(ch);
    pk      = punct_lookup(ch);
    in_num  = (scan_mode == MODE_NUM);
    in_word = (scan_mode == MODE_WORD);
    idx     = char_position - token_start;
    cont    = (in_num && dig) || (in_word && !wend);

    cand   = '0;
    cand_v = '0;

    // token ended by this character
    cand_v[0]     = (in_num || in_word) && !cont;
    cand[0].kind  = in_num ? KIND_INT : word_kind({1'b0, idx}, void_match, printl_match);
    cand[0].start = sat_out({1'b0, token_start});
    cand[0].len   = sat_out({1'b0, idx});

    mode_a = scan_mode;
    ts_a   = token_start;
    vm_a   = void_match;
    pm_a   = printl_match;

    if (cont) begin
      if (in_word) begin
        vm_a = void_match && (idx < POS_WIDTH'(4)) && (ch == void_char(idx[1:0]));
        pm_a = printl_match && (idx < POS_WIDTH'(6)) && (ch == printl_char(idx[2:0]));
      end
    end else begin
      mode_a = MODE_IDLE;
      if (dig) begin
        mode_a = MODE_NUM;
        ts_a   = char_position;
      end else if (pk[4]) begin
        cand_v[1]     = 1'b1;
        cand[1].kind  = kind_t'(pk[3:0]);
        cand[1].start = sat_out({1'b0, char_position});
        cand[1].len   = OUT_W'(1);
      end else if (alp) begin
        mode_a = MODE_WORD;
        ts_a   = char_position;
        vm_a   = (ch == 8'h76);
        pm_a   = (ch == 8'h70);
      end
    end

    sat = (char_position == POS_MAX);
    char_position_next = sat ? char_position : char_position + POS_WIDTH'(1);
    ovf = overflow_seen || sat;

    // end of text: flush pending token, then end marker
    end_pos = {1'b0, char_position} + (POS_WIDTH+1)'(1);
    len2    = end_pos - {1'b0, ts_a};
    cand_v[2]     = eoi && ((mode_a == MODE_NUM) || (mode_a == MODE_WORD));
    cand[2].kind  = (mode_a == MODE_NUM) ? KIND_INT : word_kind(len2, vm_a, pm_a);
    cand[2].start = sat_out({1'b0, ts_a});
    cand[2].len   = sat_out(len2);
    cand_v[3]     = eoi;
    cand[3].kind  = KIND_END;
    cand[3].start = sat_out(end_pos);
    cand[3].len   = '0;

    step = '0;
    cnt  = '0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k] && cnt < 2'd3) begin
        step.slot[cnt] = cand[k];
        step.slot[cnt].ovf = ovf;
        cnt = cnt + 2'd1;
      end
    end
    for (int k = 0; k < MAX_RESULTS; k++) begin
      step.slot[k].last = (2'(k) == cnt - 2'd1);
    end
    step.count = go ? cnt : 2'd0;

    if (eoi) begin
      scan_mode_next     = MODE_IDLE;
      token_start_next   = '0;
      void_match_next    = 1'b0;
      printl_match_next  = 1'b0;
      overflow_seen_next = 1'b0;
      char_position_next = '0;
    end else begin
      scan_mode_next     = mode_a;
      token_start_next   = ts_a;
      void_match_next    = vm_a;
      printl_match_next  = pm_a;
      overflow_seen_next = ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_IDLE;
      char_position <= '0;
      token_start   <= '0;
      void_match    <= 1'b0;
      printl_match  <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (go) begin
      scan_mode     <= scan_mode_next;
      char_position <= char_position_next;
      token_start   <= token_start_next;
      void_match    <= void_match_next;
      printl_match  <= printl_match_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stt_result_queue.sv =====
// ----------------------------------------------------------------------------
// stt_result_queue
// small token queue, takes up to three tokens a cycle and hands out one unless pop_stall holds
// ----------------------------------------------------------------------------
`default_nettype none

module stt_result_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire stt_pkg::step_out_t push,
  output logic                   room,
  output logic                   head_valid,
  output stt_pkg::result_t       head,
  input  wire logic              pop_stall
);
  import stt_pkg::*;

  result_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count, count_next;
  logic                pop;

  always_comb begin
    head_valid = (count != '0);
    head       = entries[rd_ptr];
    pop        = head_valid && !pop_stall;
    room       = (count <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    count_next = count + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < push.count) begin
        entries[wr_ptr + QPTR_W'(k)] <= push.slot[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/streaming_source_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// streaming_source_tokenizer_top
// character-in, token-out lexer with input register and token queue
// ----------------------------------------------------------------------------
// path: input register, then lexer and token queue, before a token is offered
// throughput: one character per cycle while the eight-entry token queue has
//   room for three tokens; output drains one token per cycle while out_stall is low
// reset: synchronous, clears scan state, position counter and queue
`default_nettype none

module streaming_source_tokenizer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  character,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       token_kind,
  output logic [15:0]      start_pos,
  output logic [15:0]      token_length,
  output logic             last_of_run,
  output logic             overflow
);
  import stt_pkg::*;

  logic        in_q_valid;
  logic [7:0]  char_q;
  logic        eoi_q;
  logic        room, go, load;
  step_out_t   step;
  result_t     head;

  assign go       = in_q_valid && room;
  assign in_stall = in_q_valid && !room;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (load) begin
      in_q_valid <= 1'b1;
    end else if (go) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_q <= character;
      eoi_q  <= end_of_input;
    end
  end

  stt_lexer u_lexer (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .ch   (char_q),
    .eoi  (eoi_q),
    .step (step)
  );

  stt_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .room       (room),
    .head_valid (out_valid),
    .head       (head),
    .pop_stall  (out_stall)
  );

  assign token_kind   = head.kind;
  assign start_pos    = head.start;
  assign token_length = head.len;
  assign last_of_run  = head.last;
  assign overflow     = head.ovf;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the streaming source tokenizer against its own token predictor.
// Source texts are queued as bytes and sent in bursts with random gaps, while
// the token side stalls on a changing pattern and holds off once for a long
// stretch. Each token that leaves the block is compared field by field with
// the oldest predicted token. The texts are short directed ones and random
// well-formed and broken ones.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 200;
  localparam logic [7:0]  SPACE_CHAR  = " ";
  localparam logic [31:0] VOID_TEXT   = "void";
  localparam logic [47:0] PRINTL_TEXT = "printl";

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } src_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  character = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  token_kind;
  logic [15:0] start_pos;
  logic [15:0] token_length;
  logic        last_of_run;
  logic        overflow;

  src_byte_t  src_q[$];
  logic [7:0] text_buf[$];
  result_t    token_q[$];

  // predictor state
  mode_t           lex_mode = MODE_IDLE;
  logic [15:0]     char_pos = '0;
  logic [15:0]     tok_start = '0;
  logic            void_ok = 1'b0;
  logic            printl_ok = 1'b0;
  logic            ovf_seen = 1'b0;

  int failures = 0;
  int tokens_seen = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int pat_mode = 0;
  int pat_left = 0;
  int pat_phase = 0;

  streaming_source_tokenizer_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .character    (character),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .start_pos    (start_pos),
    .token_length (token_length),
    .last_of_run  (last_of_run),
    .overflow     (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic word_stop(input logic [7:0] c);
    return c == SPACE_CHAR || c == ":" || c == "(" || c == ";" || c == ")";
  endfunction

  function automatic logic punct_kind_of(input logic [7:0] c, output kind_t k);
    punct_kind_of = 1'b1;
    k = KIND_END;
    case (c)
      ";":     k = KIND_SEMI;
      "=":     k = KIND_EQ;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ":":     k = KIND_COLON;
      "*":     k = KIND_STAR;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "/":     k = KIND_SLASH;
      default: punct_kind_of = 1'b0;
    endcase
  endfunction

  function automatic logic [15:0] clip16(input logic [16:0] v);
    return v[16] ? 16'hffff : v[15:0];
  endfunction

  function automatic result_t make_tok(input kind_t k, input logic [16:0] s,
                                       input logic [16:0] l);
    result_t r;
    r.kind  = k;
    r.start = clip16(s);
    r.len   = clip16(l);
    r.last  = 1'b0;
    r.ovf   = 1'b0;
    return r;
  endfunction

  function automatic kind_t name_kind(input logic [16:0] l);
    if (l == 17'd4 && void_ok) begin
      return KIND_VOID;
    end else if (l == 17'd6 && printl_ok) begin
      return KIND_PRINTL;
    end
    return KIND_IDENT;
  endfunction

  // work out the tokens one source byte causes and queue them
  task automatic lex_char(input logic [7:0] c, input logic eot);
    logic [16:0] pos;
    logic [16:0] fin;
    logic [16:0] idx;
    result_t     run[3];
    kind_t       pk;
    int          n;
    bit          absorbed;
    n = 0;
    absorbed = 1'b0;
    pos = {1'b0, char_pos};
    idx = pos - {1'b0, tok_start};
    if (lex_mode == MODE_NUM) begin
      if (digit_char(c)) begin
        absorbed = 1'b1;
      end else begin
        run[n] = make_tok(KIND_INT, {1'b0, tok_start}, idx);
        n++;
        lex_mode = MODE_IDLE;
      end
    end else if (lex_mode == MODE_WORD) begin
      if (!word_stop(c)) begin
        void_ok = void_ok && idx < 17'd4 && c == VOID_TEXT[8*(3-int'(idx[1:0])) +: 8];
        if (idx < 17'd6) begin
          printl_ok = printl_ok && c == PRINTL_TEXT[8*(5-int'(idx[2:0])) +: 8];
        end else begin
          printl_ok = 1'b0;
        end
        absorbed = 1'b1;
      end else begin
        run[n] = make_tok(name_kind(idx), {1'b0, tok_start}, idx);
        n++;
        lex_mode = MODE_IDLE;
      end
    end
    if (!absorbed) begin
      if (digit_char(c)) begin
        lex_mode = MODE_NUM;
        tok_start = char_pos;
      end else if (punct_kind_of(c, pk)) begin
        run[n] = make_tok(pk, pos, 17'd1);
        n++;
      end else if (letter_char(c)) begin
        lex_mode = MODE_WORD;
        tok_start = char_pos;
        void_ok = c == "v";
        printl_ok = c == "p";
      end
    end
    if (char_pos == POS_MAX) begin
      ovf_seen = 1'b1;
    end else begin
      char_pos = char_pos + 16'd1;
    end
    if (eot) begin
      fin = pos + 17'd1;
      if (lex_mode == MODE_NUM) begin
        run[n] = make_tok(KIND_INT, {1'b0, tok_start}, fin - {1'b0, tok_start});
        n++;
      end else if (lex_mode == MODE_WORD) begin
        run[n] = make_tok(name_kind(fin - {1'b0, tok_start}), {1'b0, tok_start},
                          fin - {1'b0, tok_start});
        n++;
      end
      run[n] = make_tok(KIND_END, fin, 17'd0);
      n++;
    end
    for (int k = 0; k < n; k++) begin
      run[k].ovf  = ovf_seen;
      run[k].last = (k == n - 1);
      token_q.insert(token_q.size(), run[k]);
    end
    if (eot) begin
      lex_mode  = MODE_IDLE;
      char_pos  = '0;
      tok_start = '0;
      void_ok   = 1'b0;
      printl_ok = 1'b0;
      ovf_seen  = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // sender: bursts with gaps, payload held while stalled
  always @(posedge clk) begin : drive
    src_byte_t nxt;
    bit take;
    bit go;
    if (!rst) begin
      take = in_valid && !in_stall;
      if (take) begin
        lex_char(character, end_of_input);
      end
      if (!in_valid || take) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (src_q.size() > 0) begin
          go = 1'b1;
          nxt = src_q.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid <= go;
        if (go) begin
          character <= nxt.ch;
          end_of_input <= nxt.eot;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin : hold_back
    bit s;
    if (!rst) begin
      s = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        s = 1'b1;
      end else if (!hold_done && tokens_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        s = 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(16, 96);
        end
        pat_left--;
        pat_phase++;
        case (pat_mode)
          1:       s = $urandom_range(0, 3) == 0;
          2:       s = (pat_phase % 3) == 0;
          3:       s = 1'($urandom_range(0, 1));
          default: s = 1'b0;
        endcase
      end
      out_stall <= s;
    end
  end

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      tokens_seen++;
      if (token_q.size() == 0) begin
        $error("token with nothing expected: kind %0d start %0d length %0d",
               token_kind, start_pos, token_length);
        failures++;
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", 32'(want.kind), 32'(token_kind));
        check_field("start_pos", 32'(want.start), 32'(start_pos));
        check_field("token_length", 32'(want.len), 32'(token_length));
        check_field("last_of_run", 32'(want.last), 32'(last_of_run));
        check_field("overflow", 32'(want.ovf), 32'(overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endtask

  task automatic add_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endtask

  task automatic flush_text();
    src_byte_t b;
    for (int i = 0; i < text_buf.size(); i++) begin
      b.ch  = text_buf[i];
      b.eot = (i == text_buf.size() - 1);
      src_q.insert(src_q.size(), b);
    end
    text_buf.delete();
  endtask

  function automatic logic [7:0] ignored_byte();
    logic [7:0] c;
    kind_t k;
    c = "0";
    while (digit_char(c) || letter_char(c) || punct_kind_of(c, k)) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      c = 8'($urandom_range(97, 122));
    end else if (sel < 8) begin
      c = 8'($urandom_range(48, 57));
    end else begin
      c = SPACE_CHAR;
      while (word_stop(c)) begin
        c = 8'($urandom_range(0, 255));
      end
    end
    return c;
  endfunction

  task automatic add_word();
    string s;
    string stops;
    stops = " :(;)";
    s = "";
    case ($urandom_range(0, 7))
      0: s = "void";
      1: s = "printl";
      2: begin
        case ($urandom_range(0, 7))
          0:       s = "voi";
          1:       s = "voidd";
          2:       s = "print";
          3:       s = "printlx";
          4:       s = "Void";
          5:       s = "printL";
          6:       s = "vo1d";
          default: s = "p";
        endcase
      end
      default: ;
    endcase
    if (s.len() > 0) begin
      add_string(s);
    end else begin
      add_byte(8'($urandom_range(0, 1) ? $urandom_range(97, 122)
                                       : $urandom_range(65, 90)));
      repeat ($urandom_range(0, 6)) add_byte(body_byte());
    end
    if ($urandom_range(0, 7) != 0) begin
      add_byte(stops[$urandom_range(0, 4)]);
    end
  endtask

  task automatic add_piece();
    string puncts;
    int sel;
    puncts = ";=(){}:*+-/";
    sel = $urandom_range(0, 15);
    if (sel < 6) begin
      add_word();
    end else if (sel < 9) begin
      repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(48, 57)));
    end else if (sel < 12) begin
      add_byte(puncts[$urandom_range(0, 10)]);
    end else if (sel < 14) begin
      add_byte(SPACE_CHAR);
    end else if (sel == 14) begin
      add_byte(ignored_byte());
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_random_texts(input int target);
    int count;
    count = 0;
    while (count < target) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) add_piece();
      end
      count += text_buf.size();
      flush_text();
    end
  endtask

  task automatic wait_drained();
    while (src_q.size() != 0 || in_valid || token_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // keywords, every punctuation word, number ended by an operator,
    // non-ascii byte inside a word, word flushed at end of text
    add_string("void(printl)");
    flush_text();
    add_string("42=+-*/{}:;q");
    add_byte(8'he9);
    flush_text();
    wait_drained();

    add_random_texts(140);
    wait_drained();
    add_random_texts(140);

    wait_drained();
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
